>>> src/sggl_pkg.sv
// ----------------------------------------------------------------------------
// sggl_pkg
// Shared types and constants of the scaled Gaussian log likelihood block.
// ----------------------------------------------------------------------------
package sggl_pkg;

	localparam int MAG_W   = 24;
	localparam int VAR_W   = 32;
	localparam int SCALE_W = 24;
	localparam int V_W     = 56;
	localparam int R2_W    = 48;
	localparam int Q_W     = 50;
	localparam int LN_W    = 24;
	localparam int SUM_W   = 48;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;
	localparam logic [Q_W-1:0]     QCAP        = 50'h2_0000_0000_0000;
	localparam logic [31:0]        LN2_Q32     = 32'd2977044472;
	localparam logic [LN_W-1:0]    LNOFS_Q16   = 24'd1969153;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MULV = 6'b000010,
		ST_MULR = 6'b000100,
		ST_WAIT = 6'b001000,
		ST_ACC  = 6'b010000,
		ST_FIN  = 6'b100000
	} top_state_t;

	typedef enum logic [3:0] {
		LG_IDLE = 4'b0001,
		LG_NORM = 4'b0010,
		LG_SQR  = 4'b0100,
		LG_LN   = 4'b1000
	} log_state_t;

	typedef struct packed {
		logic start;
	} unit_ctrl_t;

	typedef struct packed {
		logic busy;
	} unit_stat_t;

endpackage

>>> src/sggl_div.sv
// ----------------------------------------------------------------------------
// sggl_div
// Restoring divider, one quotient bit per cycle, quotient clamped to QCAP.
// ----------------------------------------------------------------------------
module sggl_div import sggl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  unit_ctrl_t       ctrl,
	input  logic [R2_W-1:0]  dividend,
	input  logic [V_W-1:0]   divisor,
	output unit_stat_t       stat,
	output logic [Q_W-1:0]   quotient
);

	localparam int NUM_W = R2_W + 30;

	logic             busy_q;
	logic [6:0]       cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [V_W-1:0]   rem_q;
	logic [V_W-1:0]   div_q;
	logic [Q_W-1:0]   quo_q;

	logic [V_W:0]     rem_sh;
	logic             ge;
	logic [V_W:0]     rem_sub;
	logic [Q_W:0]     quo_sh;

	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	assign ge      = rem_sh >= {1'b0, div_q};
	assign rem_sub = rem_sh - {1'b0, div_q};
	assign quo_sh  = {quo_q, ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 7'(NUM_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			num_q <= {dividend, 30'b0};
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= ge ? rem_sub[V_W-1:0] : rem_sh[V_W-1:0];
			// saturate: once past the cap the quotient stays there
			quo_q <= (quo_sh > {1'b0, QCAP}) ? QCAP : quo_sh[Q_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign quotient  = quo_q;

endmodule

>>> src/sggl_log.sv
// ----------------------------------------------------------------------------
// sggl_log
// ln(2*pi*V*2^-46) in Q16: normalize by single shifts, then sixteen squaring
// steps and a final multiply by ln 2, all on one 32x32 multiplier.
// ----------------------------------------------------------------------------
module sggl_log import sggl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  unit_ctrl_t             ctrl,
	input  logic [V_W-1:0]         v,
	output unit_stat_t             stat,
	output logic signed [LN_W-1:0] ln_term
);

	log_state_t state_q;
	logic [V_W-1:0]         n_q;
	logic [5:0]             e_q;
	logic [15:0]            f_q;
	logic [3:0]             cnt_q;
	logic [31:0]            m_q;
	logic signed [LN_W-1:0] ln_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [32:0] sq;
	logic [63:0] ln_rnd;

	always_comb begin
		if (state_q == LG_LN) begin
			mul_a = {10'b0, e_q, f_q};
			mul_b = LN2_Q32;
		end else begin
			mul_a = m_q;
			mul_b = m_q;
		end
	end

	assign prod   = mul_a * mul_b;
	assign sq     = prod[63:31];
	assign ln_rnd = prod + 64'h8000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LG_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				LG_IDLE: begin
					if (ctrl.start) begin
						state_q <= LG_NORM;
					end
				end
				LG_NORM: begin
					if (n_q[V_W-1]) begin
						state_q <= LG_SQR;
						cnt_q   <= '0;
					end
				end
				LG_SQR: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= LG_LN;
					end
				end
				LG_LN: begin
					state_q <= LG_IDLE;
				end
				default: begin
					state_q <= LG_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			LG_IDLE: begin
				if (ctrl.start) begin
					n_q <= v;
					e_q <= 6'(V_W - 1);
					f_q <= '0;
				end
			end
			LG_NORM: begin
				if (n_q[V_W-1]) begin
					m_q <= n_q[V_W-1 -: 32];
				end else begin
					n_q <= {n_q[V_W-2:0], 1'b0};
					e_q <= e_q - 6'd1;
				end
			end
			LG_SQR: begin
				f_q <= {f_q[14:0], sq[32]};
				m_q <= sq[32] ? sq[32:1] : sq[31:0];
			end
			LG_LN: begin
				ln_q <= $signed({2'b0, ln_rnd[53:32]}) - $signed(LNOFS_Q16);
			end
			default: begin
			end
		endcase
	end

	assign stat.busy = (state_q != LG_IDLE);
	assign ln_term   = ln_q;

endmodule

>>> src/scaled_gaussian_log_likelihood.sv
// ----------------------------------------------------------------------------
// scaled_gaussian_log_likelihood
// Accumulates -(ln(2*pi*v) + r*r/v)/2 over the bands of a star, emits on last.
// ----------------------------------------------------------------------------
// A used band passes MULV, MULR, WAIT (for the 78-step divider and the log
//   unit), ACC and FIN; a skipped band goes straight to FIN. A last band also
//   waits while the result register still holds an untaken sum.
// One band is in flight at a time: the input is ready only in the idle state.
// The result register lets the next band enter while a sum waits to be taken.
// Reset clears the sum, the output valid, the sequencer and sets scale to 1.0.
module scaled_gaussian_log_likelihood import sggl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata,     // variance_scale
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // observed_mag, model_mag, band_variance
	input  logic        s_axis_tlast,  // last_band
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // log_likelihood
);

	localparam logic signed [53:0] SUM_MAX = 54'sd140737488355327;
	localparam logic signed [53:0] SUM_MIN = -54'sd140737488355328;

	top_state_t state_q;
	logic [SCALE_W-1:0]    scale_q;
	logic [VAR_W-1:0]      var_q;
	logic [24:0]           rabs_q;
	logic                  last_q;
	logic [V_W-1:0]        v_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                  out_valid_q;
	logic [SUM_W-1:0]      out_data_q;

	logic        accept;
	logic signed [24:0] r;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	unit_ctrl_t  unit_ctrl;
	unit_stat_t  div_stat;
	unit_stat_t  log_stat;
	logic [Q_W-1:0] quotient;
	logic signed [LN_W-1:0] ln_term;
	logic signed [51:0] term;
	logic signed [51:0] half;
	logic signed [53:0] s_new;
	logic        emit;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign r = $signed({s_axis_tdata[47], s_axis_tdata[47:24]})
		- $signed({s_axis_tdata[23], s_axis_tdata[23:0]});

	always_comb begin
		if (state_q == ST_MULV) begin
			mul_a = var_q;
			mul_b = {8'b0, scale_q};
		end else begin
			mul_a = {7'b0, rabs_q};
			mul_b = {7'b0, rabs_q};
		end
	end

	assign prod = mul_a * mul_b;
	assign unit_ctrl.start = (state_q == ST_MULR);

	sggl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (unit_ctrl),
		.dividend (prod[R2_W-1:0]),
		.divisor  (v_q),
		.stat     (div_stat),
		.quotient (quotient)
	);

	sggl_log u_log (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (unit_ctrl),
		.v       (v_q),
		.stat    (log_stat),
		.ln_term (ln_term)
	);

	assign term  = 52'(ln_term) + $signed({2'b0, quotient});
	// round toward zero: bump negative terms by one before the shift
	assign half  = (term + $signed({51'b0, term[51]})) >>> 1;
	assign s_new = 54'(sum_q) - 54'(half);
	assign emit  = (state_q == ST_FIN) && last_q && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scale_q     <= SCALE_RESET;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				scale_q <= cfg_wdata;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// skip bands with a tiny variance
						state_q <= (s_axis_tdata[79:48] > 32'd1) ? ST_MULV : ST_FIN;
					end
				end
				ST_MULV: state_q <= ST_MULR;
				ST_MULR: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (!div_stat.busy && !log_stat.busy) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (s_new > SUM_MAX) begin
						sum_q <= SUM_MAX[SUM_W-1:0];
					end else if (s_new < SUM_MIN) begin
						sum_q <= SUM_MIN[SUM_W-1:0];
					end else begin
						sum_q <= s_new[SUM_W-1:0];
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (emit) begin
						sum_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			var_q  <= s_axis_tdata[79:48];
			rabs_q <= r[24] ? 25'(-r) : 25'(r);
			last_q <= s_axis_tlast;
		end
		if (state_q == ST_MULV) begin
			v_q <= (prod[V_W-1:0] == '0) ? V_W'(1) : prod[V_W-1:0];
		end
		if (emit) begin
			out_data_q <= sum_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_ready_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (!div_stat.busy && !log_stat.busy))
		else $error("input ready while a unit is busy");

	a_units_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MULR |=> (div_stat.busy && log_stat.busy))
		else $error("units did not start");

	a_skip_band: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_axis_tdata[79:48] <= 32'd1) |=> state_q == ST_FIN)
		else $error("tiny variance band not skipped");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (m_axis_tvalid && sum_q == '0))
		else $error("result not posted or sum not cleared");

endmodule
